### rtl/mwm_pkg.sv
`default_nettype none

package mwm_pkg;

  // Default width of one velocity command
  localparam int VEL_WIDTH_DEF = 16;

  localparam int LANES      = 4;
  localparam int SCALE_W    = 16;
  localparam int LIMIT_W    = 15;
  localparam int QUO_W      = 15;
  localparam int OUT_W      = 16;
  localparam int SCALE_FRAC = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_LIMIT = 2'd1;

  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 16'd32768;
  localparam logic [LIMIT_W-1:0] WHEEL_LIMIT_RST = 15'd12800;

  localparam logic [OUT_W-1:0] OUT_MAX     = 16'h7FFF;
  localparam logic [OUT_W-1:0] OUT_MIN     = 16'h8000;
  localparam logic [OUT_W-1:0] NEG_MAG_MAX = 16'd32768;

  // Per-item side information carried alongside the divider lanes
  typedef struct packed {
    logic                        norm;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][QUO_W-1:0] mag;
  } mwm_side_t;

endpackage

`default_nettype wire

### rtl/mwm_norm_div.sv
`default_nettype none

// Four-lane restoring divider, one quotient bit per stage.
module mwm_norm_div #(
  parameter int VEL_WIDTH = mwm_pkg::VEL_WIDTH_DEF
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst_n,
  input  wire logic                                               in_valid,
  output logic                                                    in_ready,
  input  wire logic [mwm_pkg::LANES-1:0][VEL_WIDTH+mwm_pkg::QUO_W:0] in_num,
  input  wire logic [VEL_WIDTH:0]                                 in_den,
  input  wire mwm_pkg::mwm_side_t                                 in_side,
  output logic                                                    out_valid,
  input  wire logic                                               out_ready,
  output logic [mwm_pkg::LANES-1:0][mwm_pkg::QUO_W-1:0]           out_quo,
  output mwm_pkg::mwm_side_t                                      out_side
);
  import mwm_pkg::*;

  localparam int MAG_W = VEL_WIDTH + 1;
  localparam int NUM_W = MAG_W + QUO_W;
  localparam int NSTG  = QUO_W;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   adv;

  logic [LANES-1:0][MAG_W-1:0] rem_r [NSTG];
  logic [LANES-1:0][QUO_W-1:0] low_r [NSTG];
  logic [LANES-1:0][QUO_W-1:0] quo_r [NSTG];
  logic [MAG_W-1:0]            den_r [NSTG];
  mwm_side_t                   side_r [NSTG];

  assign adv[NSTG] = out_ready;
  assign in_ready  = adv[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic                        prev_v;
    logic [LANES-1:0][MAG_W-1:0] rem_in;
    logic [LANES-1:0][QUO_W-1:0] low_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic [MAG_W-1:0]            den_in;
    mwm_side_t                   side_in;
    logic [LANES-1:0][MAG_W-1:0] rem_nxt;
    logic [LANES-1:0][QUO_W-1:0] low_nxt;
    logic [LANES-1:0][QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign prev_v  = in_valid;
      assign den_in  = in_den;
      assign side_in = in_side;
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign rem_in[l] = in_num[l][NUM_W-1:QUO_W];
        assign low_in[l] = in_num[l][QUO_W-1:0];
        assign quo_in[l] = '0;
      end
    end else begin : g_body
      assign prev_v  = v_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign quo_in  = quo_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      logic           ge;
      assign trial      = {rem_in[l], low_in[l][QUO_W-1]};
      assign diff       = trial - {1'b0, den_in};
      assign ge         = trial >= {1'b0, den_in};
      assign rem_nxt[l] = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      assign low_nxt[l] = {low_in[l][QUO_W-2:0], 1'b0};
      assign quo_nxt[l] = {quo_in[l][QUO_W-2:0], ge};
    end

    assign adv[k] = !v_r[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_r[k]  <= rem_nxt;
        low_r[k]  <= low_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_quo   = quo_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule

`default_nettype wire

### rtl/mecanum_wheel_mixer.sv
// Pipeline from input acceptance to a valid result word: 3 mix/peak stages,
//   15 divider stages, 1 multiply stage, 1 output stage.
// Throughput: one word per cycle while the output is taken; the 15-stage divider takes
//   one quotient bit per stage per wheel, so a new command can enter every cycle.
// Reset (rst_n low, synchronous): clears all valid bits, speed_scale = 32768,
//   wheel_limit = 12800.
`default_nettype none

module mecanum_wheel_mixer #(
  parameter int VEL_WIDTH = mwm_pkg::VEL_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [mwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mwm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // command words
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [VEL_WIDTH-1:0]       in_strafe_vel,
  input  wire logic signed [VEL_WIDTH-1:0]       in_forward_vel,
  input  wire logic signed [VEL_WIDTH-1:0]       in_turn_rate,
  // wheel words
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [mwm_pkg::OUT_W-1:0]       out_front_left_speed,
  output logic signed [mwm_pkg::OUT_W-1:0]       out_front_right_speed,
  output logic signed [mwm_pkg::OUT_W-1:0]       out_back_left_speed,
  output logic signed [mwm_pkg::OUT_W-1:0]       out_back_right_speed,
  output logic                                   out_normalized,
  output logic                                   out_saturated
);
  import mwm_pkg::*;

  localparam int MIX_W  = VEL_WIDTH + 2;   // sum of three commands
  localparam int MAG_W  = VEL_WIDTH + 1;   // |mix| <= 3 * 2^(VEL_WIDTH-1)
  localparam int NUM_W  = MAG_W + QUO_W;   // |mix| * limit
  localparam int PROD_W = QUO_W + SCALE_W; // |wheel| * speed_scale
  localparam int CMP_W  = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SCALE_W-1:0] speed_scale_r;
  logic [LIMIT_W-1:0] wheel_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r <= SPEED_SCALE_RST;
      wheel_limit_r <= WHEEL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_SCALE: speed_scale_r <= cfg_data[SCALE_W-1:0];
        CFG_WHEEL_LIMIT: wheel_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stall chain: a stage advances when it is empty or the next one advances, so bubbles
  // collapse and the input keeps flowing while the output holds, until every stage is full.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, vm_r, vo_r;
  logic adv1, adv2, adv3, advm, advo;
  logic div_in_ready, div_out_valid;

  assign advo     = !vo_r || out_ready;
  assign advm     = !vm_r || advo;
  assign adv3     = !v3_r || div_in_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // ---------------------------------------------------------------------------
  // Stage 1: form the four wheel mixes and split them into sign and magnitude
  // ---------------------------------------------------------------------------
  logic signed [MIX_W-1:0] vx, vy, wz;
  logic signed [MIX_W-1:0] mix [LANES];
  logic [MIX_W-1:0]        absv [LANES];
  logic [MAG_W-1:0]        mag1_nxt [LANES];
  logic [LANES-1:0]        neg1_nxt;
  logic [MAG_W-1:0]        mag1_r [LANES];
  logic [LANES-1:0]        neg1_r;

  always_comb begin
    vx     = MIX_W'(in_strafe_vel);
    vy     = MIX_W'(in_forward_vel);
    wz     = MIX_W'(in_turn_rate);
    mix[0] = vy + vx + wz;  // front left
    mix[1] = vy - vx - wz;  // front right
    mix[2] = vy - vx + wz;  // back left
    mix[3] = vy + vx - wz;  // back right
    for (int l = 0; l < LANES; l++) begin
      neg1_nxt[l] = mix[l][MIX_W-1];
      absv[l]     = neg1_nxt[l] ? -mix[l] : mix[l];
      mag1_nxt[l] = absv[l][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mag1_r <= mag1_nxt;
      neg1_r <= neg1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: first level of the peak tree (pairwise max)
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] mag2_r [LANES];
  logic [LANES-1:0] neg2_r;
  logic [MAG_W-1:0] pk_lo_nxt, pk_hi_nxt, pk_lo_r, pk_hi_r;

  assign pk_lo_nxt = (mag1_r[0] > mag1_r[1]) ? mag1_r[0] : mag1_r[1];
  assign pk_hi_nxt = (mag1_r[2] > mag1_r[3]) ? mag1_r[2] : mag1_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      pk_lo_r <= pk_lo_nxt;
      pk_hi_r <= pk_hi_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: final peak, limit compare, and |mix| * limit numerators.
  // When the peak is within the limit every magnitude fits in 15 bits,
  // so the side path carries them that narrow.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]            peak;
  logic [LANES-1:0][NUM_W-1:0] num3_nxt, num3_r;
  mwm_side_t                   side3_nxt, side3_r;
  logic [MAG_W-1:0]            den3_r;

  always_comb begin
    peak           = (pk_lo_r > pk_hi_r) ? pk_lo_r : pk_hi_r;
    side3_nxt.norm = CMP_W'(peak) > CMP_W'(wheel_limit_r);
    side3_nxt.neg  = neg2_r;
    for (int l = 0; l < LANES; l++) begin
      num3_nxt[l]      = NUM_W'(mag2_r[l]) * NUM_W'(wheel_limit_r);
      side3_nxt.mag[l] = QUO_W'(mag2_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      num3_r  <= num3_nxt;
      den3_r  <= peak;
      side3_r <= side3_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Normalization divider: |mix| * limit / peak for all four wheels
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][QUO_W-1:0] div_quo;
  mwm_side_t                   div_side;

  mwm_norm_div #(
    .VEL_WIDTH (VEL_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .in_num    (num3_r),
    .in_den    (den3_r),
    .in_side   (side3_r),
    .out_valid (div_out_valid),
    .out_ready (advm),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---------------------------------------------------------------------------
  // Multiply stage: pick scaled or raw magnitude, multiply by speed_scale
  // ---------------------------------------------------------------------------
  logic [QUO_W-1:0]  wmag [LANES];
  logic [PROD_W-1:0] prod_nxt [LANES];
  logic [PROD_W-1:0] prod_r [LANES];
  logic [LANES-1:0]  negm_r;
  logic              normm_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wmag[l]     = div_side.norm ? div_quo[l] : div_side.mag[l];
      prod_nxt[l] = PROD_W'(wmag[l]) * PROD_W'(speed_scale_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (advm) begin
      vm_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advm) begin
      prod_r  <= prod_nxt;
      negm_r  <= div_side.neg;
      normm_r <= div_side.norm;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: drop the UQ1.15 fraction (toward zero in sign-magnitude),
  // restore the sign and clip to 16 bits. Holds the word until taken.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] pmag [LANES];
  logic [LANES-1:0] clip;
  logic [OUT_W-1:0] spd_nxt [LANES];
  logic [OUT_W-1:0] spd_r [LANES];
  logic             norm_o_r, sat_o_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pmag[l] = prod_r[l][PROD_W-1:SCALE_FRAC];
      if (negm_r[l]) begin
        clip[l]    = pmag[l] > NEG_MAG_MAX;
        spd_nxt[l] = clip[l] ? OUT_MIN : -pmag[l];
      end else begin
        clip[l]    = pmag[l] > OUT_MAX;
        spd_nxt[l] = clip[l] ? OUT_MAX : pmag[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (advo) begin
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advo) begin
      spd_r    <= spd_nxt;
      norm_o_r <= normm_r;
      sat_o_r  <= |clip;
    end
  end

  assign out_valid             = vo_r;
  assign out_front_left_speed  = spd_r[0];
  assign out_front_right_speed = spd_r[1];
  assign out_back_left_speed   = spd_r[2];
  assign out_back_right_speed  = spd_r[3];
  assign out_normalized        = norm_o_r;
  assign out_saturated         = sat_o_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The input may only stall when every stage is full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the pipeline had room");

  // An accepted command word lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted word lost at stage 1");

  // A clipped word carries at least one wheel at a rail.
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (spd_r[0] == OUT_MAX || spd_r[0] == OUT_MIN ||
       spd_r[1] == OUT_MAX || spd_r[1] == OUT_MIN ||
       spd_r[2] == OUT_MAX || spd_r[2] == OUT_MIN ||
       spd_r[3] == OUT_MAX || spd_r[3] == OUT_MIN))
    else $error("saturated flag set with no wheel at a rail");

endmodule

`default_nettype wire

### bench/mecanum_wheel_mixer_test.sv
module mecanum_wheel_mixer_test;
  import mwm_pkg::*;

  localparam int VEL_W       = VEL_WIDTH_DEF;
  localparam int IDLE_PCT    = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 200000;

  // Indexes the block does not decode; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // One expected wheel word: the four wheel commands plus both flags
  typedef struct packed {
    logic [LANES-1:0][OUT_W-1:0] speed;
    logic                        norm;
    logic                        sat;
  } wheel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VEL_W-1:0] in_strafe_vel = '0;
  logic signed [VEL_W-1:0] in_forward_vel = '0;
  logic signed [VEL_W-1:0] in_turn_rate = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_front_left_speed;
  logic signed [OUT_W-1:0] out_front_right_speed;
  logic signed [OUT_W-1:0] out_back_left_speed;
  logic signed [OUT_W-1:0] out_back_right_speed;
  logic                    out_normalized;
  logic                    out_saturated;

  // Our own copy of the two registers, updated on every write we issue
  logic [SCALE_W-1:0] scale_q = SPEED_SCALE_RST;
  logic [LIMIT_W-1:0] limit_q = WHEEL_LIMIT_RST;

  wheel_word_t pending_wheels[$];
  wheel_word_t got_word;
  int          err_count = 0;

  // Quiet turns off random idling on both sides
  bit quiet = 1'b0;

  // Long receiver hold: the test side bumps hold_req, the receiver counts it out
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  mecanum_wheel_mixer i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_strafe_vel         (in_strafe_vel),
    .in_forward_vel        (in_forward_vel),
    .in_turn_rate          (in_turn_rate),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_front_left_speed  (out_front_left_speed),
    .out_front_right_speed (out_front_right_speed),
    .out_back_left_speed   (out_back_left_speed),
    .out_back_right_speed  (out_back_right_speed),
    .out_normalized        (out_normalized),
    .out_saturated         (out_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops words
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Mix, normalize against the limit, apply the speed scale and clip.
  // Every division truncates toward zero, as the block does.
  function automatic wheel_word_t mix_wheels(input logic signed [VEL_W-1:0] strafe,
                                             input logic signed [VEL_W-1:0] fwd,
                                             input logic signed [VEL_W-1:0] turn);
    longint      vx, vy, w, peak, p, lim, hi, lo;
    longint      mix[LANES];
    wheel_word_t res;
    vx   = strafe;
    vy   = fwd;
    w    = turn;
    lim  = longint'(limit_q);
    hi   = longint'(OUT_MAX);
    lo   = longint'($signed(OUT_MIN));
    res  = '0;
    mix[0] = vy + vx + w;
    mix[1] = vy - vx - w;
    mix[2] = vy - vx + w;
    mix[3] = vy + vx - w;
    peak = 0;
    for (int i = 0; i < LANES; i++) begin
      if ((mix[i] < 0 ? -mix[i] : mix[i]) > peak) peak = (mix[i] < 0 ? -mix[i] : mix[i]);
    end
    // Strictly above the limit only: a peak equal to it passes untouched
    if (peak > lim) begin
      res.norm = 1'b1;
      for (int i = 0; i < LANES; i++) mix[i] = (mix[i] * lim) / peak;
    end
    for (int i = 0; i < LANES; i++) begin
      p = (mix[i] * longint'(scale_q)) / (longint'(1) << SCALE_FRAC);
      if (p > hi) begin
        p = hi;
        res.sat = 1'b1;
      end else if (p < lo) begin
        p = lo;
        res.sat = 1'b1;
      end
      res.speed[i] = OUT_W'(p);
    end
    return res;
  endfunction

  // Full-range values in the largest share, with others within half the limit, small values and extremes
  function automatic logic signed [VEL_W-1:0] rand_vel();
    int half;
    int v;
    half = int'(limit_q) / 2;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom);
      4, 5, 6:    v = int'($urandom_range(0, 2 * half)) - half;
      7: begin
        case ($urandom_range(4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 1;
          3:       v = -1;
          default: v = 0;
        endcase
      end
      default:    v = int'($urandom_range(0, 8192)) - 4096;
    endcase
    return VEL_W'(v);
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // Offer one command word, hold it until taken, then maybe drop valid for a single cycle.
  // Valid stays high across back-to-back words.
  task automatic send_cmd(input logic signed [VEL_W-1:0] strafe,
                          input logic signed [VEL_W-1:0] fwd,
                          input logic signed [VEL_W-1:0] turn);
    in_valid       <= 1'b1;
    in_strafe_vel  <= strafe;
    in_forward_vel <= fwd;
    in_turn_rate   <= turn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_wheels.push_back(mix_wheels(strafe, fwd, turn));
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected wheel word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_wheels.size() != 0) @(posedge clk);
  endtask

  // One register write; cfg_we drops again before the task returns, so write enables never abut
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPEED_SCALE) scale_q = val;
    else if (idx == CFG_WHEEL_LIMIT) limit_q = val[LIMIT_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_cmd(rand_vel(), rand_vel(), rand_vel());
  endtask

  // Reset values of both registers: zero, each axis alone, field extremes,
  // and a peak sitting exactly on the limit versus one step above it
  task automatic test_reset_defaults();
    send_cmd(16'sd0, 16'sd0, 16'sd0);
    send_cmd(16'sd32767, 16'sd32767, 16'sd32767);
    send_cmd(-16'sd32768, -16'sd32768, -16'sd32768);
    send_cmd(16'sd32767, 16'sd0, 16'sd0);
    send_cmd(16'sd0, -16'sd32768, 16'sd0);
    send_cmd(16'sd0, 16'sd0, 16'sd32767);
    send_cmd(16'sd32767, -16'sd32768, 16'sd32767);
    send_cmd(16'sd0, 16'sd12800, 16'sd0);
    send_cmd(16'sd0, 16'sd12801, 16'sd0);
    send_cmd(16'sd100, -16'sd200, 16'sd300);
    drain();
  endtask

  // Highest limit and scale: large mixes must clip to 16 bits
  task automatic test_saturation();
    write_reg(CFG_WHEEL_LIMIT, 16'd32767);
    write_reg(CFG_SPEED_SCALE, 16'd65535);
    send_cmd(16'sd0, 16'sd32767, 16'sd0);
    send_cmd(16'sd32767, 16'sd32767, 16'sd32767);
    send_cmd(-16'sd32768, -16'sd32768, -16'sd32768);
    send_cmd(16'sd1, 16'sd0, 16'sd0);
    drain();
  endtask

  // Zero limit: any nonzero mix collapses to zero with the normalize flag set
  task automatic test_zero_limit();
    write_reg(CFG_WHEEL_LIMIT, 16'd0);
    send_cmd(16'sd0, 16'sd0, 16'sd0);
    send_cmd(16'sd5, -16'sd7, 16'sd3);
    send_cmd(-16'sd32768, 16'sd32767, -16'sd1);
    drain();
  endtask

  // Bits above the limit width are dropped, spare indexes are ignored,
  // and a zero scale forces every wheel to zero
  task automatic test_reg_decode();
    write_reg(CFG_WHEEL_LIMIT, 16'hFFFF);
    write_reg(CFG_SPEED_SCALE, 16'd0);
    write_reg(CFG_SPARE_LO, 16'h1234);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    send_cmd(16'sd32767, 16'sd32767, -16'sd32768);
    send_cmd(16'sd1000, 16'sd2000, 16'sd3000);
    drain();
    write_reg(CFG_WHEEL_LIMIT, 16'd1);
    write_reg(CFG_SPEED_SCALE, 16'd1);
    send_cmd(16'sd32767, 16'sd0, 16'sd0);
    send_cmd(-16'sd1, 16'sd0, 16'sd0);
    drain();
  endtask

  // Random words under a spread of settings, one of them with no idling
  task automatic test_random_settings();
    write_reg(CFG_WHEEL_LIMIT, WHEEL_LIMIT_RST);
    write_reg(CFG_SPEED_SCALE, SPEED_SCALE_RST);
    send_random(70);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_WHEEL_LIMIT, CFG_DATA_W'($urandom_range(1, 32767)));
      write_reg(CFG_SPEED_SCALE, CFG_DATA_W'($urandom));
      quiet = (phase == 2);
      send_random(70);
      drain();
    end
    quiet = 1'b0;
  endtask

  // Stall the receiver for a long stretch while words keep coming, so the
  // pipeline fills and input ready must drop
  task automatic test_backpressure();
    write_reg(CFG_WHEEL_LIMIT, 16'd32767);
    write_reg(CFG_SPEED_SCALE, 16'd49152);
    quiet    = 1'b1;
    hold_req <= hold_req + 1;
    send_random(60);
    quiet = 1'b0;
    drain();
  endtask

  // Receiver: random stalls, with an occasional long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every accepted wheel word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_wheels.size() == 0) begin
        $error("wheel word arrived with no command pending");
        err_count++;
      end else begin
        got_word = pending_wheels.pop_front();
        compare_field("front_left_speed", $signed(got_word.speed[0]), out_front_left_speed);
        compare_field("front_right_speed", $signed(got_word.speed[1]), out_front_right_speed);
        compare_field("back_left_speed", $signed(got_word.speed[2]), out_back_left_speed);
        compare_field("back_right_speed", $signed(got_word.speed[3]), out_back_right_speed);
        compare_field("normalized", got_word.norm, out_normalized);
        compare_field("saturated", got_word.sat, out_saturated);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_saturation();
    test_zero_limit();
    test_reg_decode();
    test_random_settings();
    test_backpressure();

    // Let any stray word show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0 && pending_wheels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
